FILE: sv/wdef_pkg.sv
// ----------------------------------------------------------------------------
// wdef_pkg
// Shared types and constants for the 802.11 data to Ethernet frame converter.
// ----------------------------------------------------------------------------
package wdef_pkg;

    // 802.11 frame control fields
    localparam logic [15:0] FCTL_KIND_MASK = 16'h000C;
    localparam logic [15:0] FCTL_KIND_DATA = 16'h0008;
    localparam logic [15:0] FCTL_TO_DS     = 16'h0100;
    localparam logic [15:0] FCTL_FROM_DS   = 16'h0200;
    localparam logic [7:0]  SNAP_SAP_VALUE = 8'hAA;

    // header sizes in bytes
    localparam int ETH_HEAD_BYTES = 14;
    localparam int HDR_TOTAL      = 32;

    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    // default queue depths
    localparam int TOK_QUEUE_DEPTH = 16;
    localparam int HDR_QUEUE_DEPTH = 2;

    // token kinds carried from front to back
    localparam logic [1:0] TK_BYTE = 2'd0;
    localparam logic [1:0] TK_HDR  = 2'd1;
    localparam logic [1:0] TK_REJ  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_tok;

    // Ethernet header, element k is emitted k-th
    typedef logic [ETH_HEAD_BYTES-1:0][7:0] t_eth_hdr;

    typedef struct packed {
        logic     tok_push;
        t_tok     tok;
        logic     hdr_push;
        t_eth_hdr hdr;
    } t_front_push;

endpackage

FILE: sv/wdef_queue.sv
// ----------------------------------------------------------------------------
// wdef_queue
// Small first-in first-out queue with head shown combinationally.
// ----------------------------------------------------------------------------
module wdef_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

endmodule

FILE: sv/wdef_front.sv
// ----------------------------------------------------------------------------
// wdef_front
// Captures the 802.11 and LLC/SNAP header, checks the frame and queues tokens.
// ----------------------------------------------------------------------------
module wdef_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    input  logic [7:0]           i_data_byte,
    input  logic [15:0]          i_frame_length,
    input  logic                 i_tok_full,
    input  logic                 i_hdr_full,
    output logic                 o_stall,
    output wdef_pkg::t_front_push o_push
);
    import wdef_pkg::*;

    logic [15:0] r_pos;
    logic        r_accepted;
    logic [15:0] r_cap;
    logic [7:0]  r_hdr [HDR_TOTAL];

    logic [15:0] n_pos;
    logic        n_accepted;
    logic        take;
    logic        last;
    logic        in_hdr;
    logic        at_check;
    logic [15:0] fc;
    logic        hdr_ok;
    logic        tods;
    logic        fromds;
    t_eth_hdr    eth;

    assign o_stall  = i_tok_full | i_hdr_full;
    assign take     = i_valid & ~o_stall;
    assign last     = ({1'b0, r_pos} + 17'd1) >= {1'b0, i_frame_length};
    assign in_hdr   = (r_pos[15:5] == '0);
    assign at_check = (r_pos == 16'(HDR_TOTAL - 1));

    assign fc     = {r_hdr[1], r_hdr[0]};
    assign tods   = (fc & FCTL_TO_DS) != '0;
    assign fromds = (fc & FCTL_FROM_DS) != '0;

    always_comb begin
        hdr_ok = (i_frame_length >= 16'(HDR_TOTAL))
               && ((fc & FCTL_KIND_MASK) == FCTL_KIND_DATA)
               && !(tods && fromds)
               && (r_hdr[24] == SNAP_SAP_VALUE)
               && (r_hdr[25] == SNAP_SAP_VALUE)
               && (({1'b0, i_frame_length} - 17'(HDR_TOTAL - ETH_HEAD_BYTES))
                   <= {1'b0, r_cap});
    end

    // pick destination and source by the distribution system bits
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            eth[k]     = tods   ? r_hdr[16 + k] : r_hdr[4 + k];
            eth[6 + k] = fromds ? r_hdr[16 + k] : r_hdr[10 + k];
        end
        eth[12] = r_hdr[30];
        eth[13] = i_data_byte;
    end

    always_comb begin
        o_push          = '0;
        o_push.hdr      = eth;
        o_push.tok.data = i_data_byte;
        o_push.tok.last = last;
        n_accepted      = r_accepted;
        n_pos           = r_pos;
        if (take) begin
            if (in_hdr) begin
                if (at_check) begin
                    n_accepted = hdr_ok;
                    if (hdr_ok) begin
                        o_push.tok_push = 1'b1;
                        o_push.hdr_push = 1'b1;
                        o_push.tok.kind = TK_HDR;
                    end else if (last) begin
                        o_push.tok_push = 1'b1;
                        o_push.tok.kind = TK_REJ;
                    end
                end else if (last) begin
                    o_push.tok_push = 1'b1;
                    o_push.tok.kind = TK_REJ;
                end
            end else if (r_accepted) begin
                o_push.tok_push = 1'b1;
                o_push.tok.kind = TK_BYTE;
            end else if (last) begin
                o_push.tok_push = 1'b1;
                o_push.tok.kind = TK_REJ;
            end
            if (o_push.tok.kind == TK_REJ) begin
                o_push.tok.data = '0;
            end
            if (last) begin
                n_pos      = '0;
                n_accepted = 1'b0;
            end else begin
                n_pos = r_pos + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_accepted <= 1'b0;
            r_cap      <= CAP_RESET;
        end else begin
            r_pos      <= n_pos;
            r_accepted <= n_accepted;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && in_hdr) begin
            r_hdr[r_pos[4:0]] <= i_data_byte;
        end
    end

endmodule

FILE: sv/wdef_back.sv
// ----------------------------------------------------------------------------
// wdef_back
// Expands queued tokens into Ethernet bytes through a registered output stage.
// ----------------------------------------------------------------------------
module wdef_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wdef_pkg::t_tok     i_tok,
    input  logic               i_tok_empty,
    input  wdef_pkg::t_eth_hdr i_hdr,
    output logic               o_tok_pop,
    output logic               o_hdr_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_last_out,
    output logic               o_status
);
    import wdef_pkg::*;

    localparam int HW = $clog2(ETH_HEAD_BYTES);

    logic          r_valid;
    logic [7:0]    r_byte;
    logic          r_last;
    logic          r_status;
    logic [HW-1:0] r_hcnt;

    logic          n_valid;
    logic [7:0]    n_byte;
    logic          n_last;
    logic          n_status;
    logic [HW-1:0] n_hcnt;
    logic          load;

    assign load = ~r_valid | ~i_stall;

    always_comb begin
        n_valid   = r_valid;
        n_byte    = r_byte;
        n_last    = r_last;
        n_status  = r_status;
        n_hcnt    = r_hcnt;
        o_tok_pop = 1'b0;
        o_hdr_pop = 1'b0;
        if (load) begin
            n_valid = 1'b0;
            if (!i_tok_empty) begin
                unique case (i_tok.kind)
                    TK_BYTE: begin
                        n_valid   = 1'b1;
                        n_byte    = i_tok.data;
                        n_last    = i_tok.last;
                        n_status  = 1'b0;
                        o_tok_pop = 1'b1;
                    end
                    TK_REJ: begin
                        n_valid   = 1'b1;
                        n_byte    = '0;
                        n_last    = 1'b1;
                        n_status  = 1'b1;
                        o_tok_pop = 1'b1;
                    end
                    TK_HDR: begin
                        n_valid  = 1'b1;
                        n_byte   = i_hdr[r_hcnt];
                        n_status = 1'b0;
                        if (r_hcnt == HW'(ETH_HEAD_BYTES - 1)) begin
                            // header done: retire both entries
                            n_last    = i_tok.last;
                            n_hcnt    = '0;
                            o_tok_pop = 1'b1;
                            o_hdr_pop = 1'b1;
                        end else begin
                            n_last = 1'b0;
                            n_hcnt = r_hcnt + HW'(1);
                        end
                    end
                    default: begin
                        // drop unknown token
                        o_tok_pop = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hcnt  <= '0;
        end else begin
            r_valid <= n_valid;
            r_hcnt  <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last_out = r_last;
    assign o_status   = r_status;

endmodule

FILE: sv/wlan_data_to_ethernet_frame.sv
// ----------------------------------------------------------------------------
// wlan_data_to_ethernet_frame
// 802.11 data frame to Ethernet frame translation, one byte per item.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while o_stall is low and gives one Ethernet
// result per cycle while tokens are queued and i_stall is low. The front captures
// the 32-byte MAC plus LLC/SNAP header, checks the frame on its 32nd byte and
// queues one token per result group; the back turns a header token into 14 output
// bytes, payload and reject tokens into one result each. The 14-byte burst is
// absorbed by the token queue (TOK_QUEUE_DEPTH entries) and the header queue
// (HDR_QUEUE_DEPTH snapshots); o_stall rises only when one of them is full.
// Output results leave a registered stage that follows the token queue.
// The capacity register may be written at any time the block is idle;
// o_cfg_ready is always high.
// ----------------------------------------------------------------------------
module wlan_data_to_ethernet_frame #(
    parameter int TOK_DEPTH = wdef_pkg::TOK_QUEUE_DEPTH,
    parameter int HDR_DEPTH = wdef_pkg::HDR_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_frame_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_out,
    output logic        o_status
);
    import wdef_pkg::*;

    t_front_push push;
    t_tok        tok_head;
    t_eth_hdr    hdr_head;
    logic        tok_empty;
    logic        tok_full;
    logic        hdr_empty;
    logic        hdr_full;
    logic        tok_pop;
    logic        hdr_pop;

    assign o_cfg_ready = 1'b1;

    wdef_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_data_byte    (i_data_byte),
        .i_frame_length (i_frame_length),
        .i_tok_full     (tok_full),
        .i_hdr_full     (hdr_full),
        .o_stall        (o_stall),
        .o_push         (push)
    );

    wdef_queue #(
        .DEPTH (TOK_DEPTH),
        .WIDTH ($bits(t_tok))
    ) u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push.tok_push),
        .i_data  (push.tok),
        .i_pop   (tok_pop),
        .o_data  (tok_head),
        .o_empty (tok_empty),
        .o_full  (tok_full)
    );

    wdef_queue #(
        .DEPTH (HDR_DEPTH),
        .WIDTH ($bits(t_eth_hdr))
    ) u_hdr_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push.hdr_push),
        .i_data  (push.hdr),
        .i_pop   (hdr_pop & ~hdr_empty),
        .o_data  (hdr_head),
        .o_empty (hdr_empty),
        .o_full  (hdr_full)
    );

    wdef_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok_head),
        .i_tok_empty (tok_empty),
        .i_hdr       (hdr_head),
        .o_tok_pop   (tok_pop),
        .o_hdr_pop   (hdr_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_out  (o_last_out),
        .o_status    (o_status)
    );

endmodule

FILE: verif/wlan_data_to_ethernet_frame_test.sv
// ----------------------------------------------------------------------------
// wlan_data_to_ethernet_frame_test
// Self-checking bench for the 802.11 data to Ethernet frame converter.
// ----------------------------------------------------------------------------
// Feeds 802.11 frames one byte per item: good data frames with all address
// modes, four-address, non-data, bad LLC/SNAP, short and length-changing
// frames, under several capacity settings. A scoreboard class predicts every
// Ethernet result and checks the block's output stream field by field. Both
// sides insert random idle cycles, and the receiver once holds off long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
module wlan_data_to_ethernet_frame_test;
    import wdef_pkg::*;

    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 100000;

    // ToDS is bit 0 and FromDS bit 1 of the second frame control byte
    localparam logic [1:0] DS_NONE = 2'b00;
    localparam logic [1:0] DS_TO   = 2'b01;
    localparam logic [1:0] DS_FROM = 2'b10;
    localparam logic [1:0] DS_BOTH = 2'b11;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rejected;
    } t_eth_result;

    class t_frame_tracker;
        logic [7:0]  hdr[HDR_TOTAL];
        int unsigned pos;
        bit          accepted;
        logic [15:0] capacity;
        t_eth_result eth_bytes_due[$];
        int          errors;

        function new();
            foreach (hdr[i]) hdr[i] = 8'h00;
            pos      = 0;
            accepted = 1'b0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function int pending();
            return eth_bytes_due.size();
        endfunction

        function void push(logic [7:0] data, logic last, logic rejected);
            t_eth_result r;
            r.data     = data;
            r.last     = last;
            r.rejected = rejected;
            eth_bytes_due.push_back(r);
        endfunction

        function bit header_ok(int unsigned len);
            logic [15:0] fc;
            fc = {hdr[1], hdr[0]};
            if (len < HDR_TOTAL) return 1'b0;
            if ((fc & FCTL_KIND_MASK) != FCTL_KIND_DATA) return 1'b0;
            if ((fc & (FCTL_TO_DS | FCTL_FROM_DS)) == (FCTL_TO_DS | FCTL_FROM_DS)) return 1'b0;
            if (hdr[24] != SNAP_SAP_VALUE || hdr[25] != SNAP_SAP_VALUE) return 1'b0;
            if (ETH_HEAD_BYTES + (len - HDR_TOTAL) > int'(capacity)) return 1'b0;
            return 1'b1;
        endfunction

        function void take_wlan_byte(logic [7:0] b, logic [15:0] len);
            bit          last;
            logic [15:0] fc;
            int unsigned da;
            int unsigned sa;
            last = (pos + 1) >= int'(len);
            if (pos < HDR_TOTAL) begin
                hdr[pos] = b;
                if (pos == HDR_TOTAL - 1) begin
                    accepted = header_ok(len);
                    if (accepted) begin
                        fc = {hdr[1], hdr[0]};
                        da = 4;
                        sa = 10;
                        if ((fc & (FCTL_TO_DS | FCTL_FROM_DS)) == FCTL_FROM_DS) begin
                            sa = 16;
                        end else if ((fc & (FCTL_TO_DS | FCTL_FROM_DS)) == FCTL_TO_DS) begin
                            da = 16;
                        end
                        for (int i = 0; i < 6; i++) push(hdr[da + i], 1'b0, 1'b0);
                        for (int i = 0; i < 6; i++) push(hdr[sa + i], 1'b0, 1'b0);
                        push(hdr[30], 1'b0, 1'b0);
                        push(hdr[31], last, 1'b0);
                    end else if (last) begin
                        push(8'h00, 1'b1, 1'b1);
                    end
                end else if (last) begin
                    accepted = 1'b0;
                    push(8'h00, 1'b1, 1'b1);
                end
            end else if (accepted) begin
                push(b, last, 1'b0);
            end else if (last) begin
                push(8'h00, 1'b1, 1'b1);
            end
            if (last) begin
                pos      = 0;
                accepted = 1'b0;
            end else begin
                pos++;
            end
        endfunction

        function void match_eth_result(logic [7:0] data, logic last, logic rejected);
            t_eth_result e;
            if (eth_bytes_due.size() == 0) begin
                $display("%0t ERROR: unexpected result out_byte=%h last_out=%b status=%b",
                         $time, data, last, rejected);
                errors++;
                return;
            end
            e = eth_bytes_due.pop_front();
            if (e.data !== data) begin
                $display("%0t ERROR: out_byte expected %h actual %h", $time, e.data, data);
                errors++;
            end
            if (e.last !== last) begin
                $display("%0t ERROR: last_out expected %b actual %b", $time, e.last, last);
                errors++;
            end
            if (e.rejected !== rejected) begin
                $display("%0t ERROR: status expected %b actual %b", $time, e.rejected, rejected);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic [15:0] i_frame_length;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_out;
    logic        o_status;

    t_frame_tracker   tracker;
    logic [7:0]       hdr_buf[HDR_TOTAL];
    int unsigned      items_sent = 0;
    int unsigned      cycles = 0;
    bit               no_idle = 1'b0;
    int               hold_requests = 0;
    int               hold_granted = 0;
    int               hold_left = 0;
    int               rx_gap = 0;

    wlan_data_to_ethernet_frame u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_frame_length (i_frame_length),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last_out     (o_last_out),
        .o_status       (o_status)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stall per item, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.match_eth_result(o_out_byte, o_last_out, o_status);
            rx_gap = no_idle ? 0 : $urandom_range(0, 3);
        end
        if (hold_granted != hold_requests) begin
            hold_left    = LONG_HOLD;
            hold_granted = hold_requests;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [15:0] len);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= b;
        i_frame_length <= len;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_wlan_byte(b, len);
        items_sent++;
    endtask

    // all bytes but the final one carry len_main
    task automatic send_frame(input int unsigned payload, input logic [15:0] len_main,
                              input logic [15:0] len_last);
        int unsigned total;
        total = HDR_TOTAL + payload;
        for (int unsigned i = 0; i < total; i++) begin
            send_byte((i < HDR_TOTAL) ? hdr_buf[i] : 8'($urandom),
                      (i == total - 1) ? len_last : len_main);
        end
    endtask

    task automatic send_short();
        int unsigned n;
        n = $urandom_range(1, HDR_TOTAL - 1);
        for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom), 16'(n));
    endtask

    function automatic void fill_header(input logic [1:0] ds, input bit is_data,
                                        input bit snap_ok);
        logic [1:0] ftype;
        int         which;
        foreach (hdr_buf[i]) hdr_buf[i] = 8'($urandom);
        ftype = FCTL_KIND_DATA[3:2];
        if (!is_data) begin
            while (ftype == FCTL_KIND_DATA[3:2]) ftype = 2'($urandom_range(0, 3));
        end
        hdr_buf[0][3:2] = ftype;
        hdr_buf[1][1:0] = ds;
        hdr_buf[24]     = SNAP_SAP_VALUE;
        hdr_buf[25]     = SNAP_SAP_VALUE;
        if (!snap_ok) begin
            which = $urandom_range(0, 2);
            if (which != 1) hdr_buf[24] = SNAP_SAP_VALUE ^ 8'($urandom_range(1, 255));
            if (which != 0) hdr_buf[25] = SNAP_SAP_VALUE ^ 8'($urandom_range(1, 255));
        end
    endfunction

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        drain_and_settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracker.capacity = value;
    endtask

    task automatic random_frames(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        int unsigned p;
        logic [1:0]  ds;
        start = items_sent;
        while (items_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            p    = $urandom_range(0, 12);
            ds   = 2'($urandom_range(0, 2));
            if (pick < 55) begin
                fill_header(ds, 1'b1, 1'b1);
                send_frame(p, 16'(HDR_TOTAL + p), 16'(HDR_TOTAL + p));
            end else if (pick < 63) begin
                fill_header(DS_BOTH, 1'b1, 1'b1);
                send_frame(p, 16'(HDR_TOTAL + p), 16'(HDR_TOTAL + p));
            end else if (pick < 71) begin
                fill_header(2'($urandom_range(0, 3)), 1'b0, 1'b1);
                send_frame(p, 16'(HDR_TOTAL + p), 16'(HDR_TOTAL + p));
            end else if (pick < 79) begin
                fill_header(ds, 1'b1, 1'b0);
                send_frame(p, 16'(HDR_TOTAL + p), 16'(HDR_TOTAL + p));
            end else if (pick < 90) begin
                send_short();
            end else begin
                // length may change on the final byte and cut the frame short
                fill_header(ds, 1'b1, 1'b1);
                send_frame(p, 16'($urandom_range(HDR_TOTAL + p, 65535)),
                           16'($urandom_range(1, HDR_TOTAL + p)));
            end
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= 16'h0000;
        i_valid        <= 1'b0;
        i_data_byte    <= 8'h00;
        i_frame_length <= 16'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-byte frame, rejected as short
        send_byte(8'hFF, 16'd1);
        // exact 32-byte ToDS frame, addresses at both byte extremes
        fill_header(DS_TO, 1'b1, 1'b1);
        for (int i = 4; i < 22; i++) hdr_buf[i] = (i % 2) ? 8'hFF : 8'h00;
        send_frame(0, 16'd32, 16'd32);
        // largest length on the check byte, then cut to one byte at the end
        fill_header(DS_FROM, 1'b1, 1'b1);
        send_frame(1, 16'hFFFF, 16'd1);

        write_capacity(16'd0);
        random_frames(25);
        write_capacity(16'd14);
        random_frames(25);
        write_capacity(16'($urandom_range(15, 26)));
        random_frames(25);

        write_capacity(16'hFFFF);
        // back the block up: long receiver hold-off against a long frame
        hold_requests++;
        no_idle = 1'b1;
        fill_header(DS_NONE, 1'b1, 1'b1);
        send_frame(24, 16'd56, 16'd56);
        drain_and_settle();
        random_frames(20);
        no_idle = 1'b0;
        random_frames(25);

        drain_and_settle();
        if (tracker.pending() != 0) begin
            $display("%0t ERROR: %0d results never arrived", $time, tracker.pending());
        end
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: wlan_data_to_ethernet_frame.f
sv/wdef_pkg.sv
sv/wdef_queue.sv
sv/wdef_front.sv
sv/wdef_back.sv
sv/wlan_data_to_ethernet_frame.sv
verif/wlan_data_to_ethernet_frame_test.sv
